// ----- rtl/core/lphs_pkg.sv -----
package lphs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BITS    = 31;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_W = 9;
   localparam logic [CSR_W-1:0] CSR_RESET = 9'd256;

   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = (KEY_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int DIV_BITS       = DIV_STEPS * DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

   localparam int LOAD_W = CNT_W + 4;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_LOAD    = 3'd1,
      ST_DUP     = 3'd2,
      ST_MISSING = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DIV,
      FSM_ISSUE,
      FSM_CHECK,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic                func;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] entry_total;
   } rsp_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      slot_state_type      wr_slot;
      logic [KEY_BITS-1:0] wr_key;
   } tbl_req_type;

   typedef struct packed {
      slot_state_type      slot;
      logic [KEY_BITS-1:0] key;
   } tbl_rd_type;

endpackage

// ----- rtl/core/linear_probe_hash_set_core.sv -----
// Each operation runs the key modulo unit, then a table read and a check for each slot
// probed (1 up to the table size), then presents its result; a load refusal skips the probes.
// A new input is taken only while idle, after the result of the last one has been given.
// Reset clears the slot valid bits and the entry count at once; the size register resets to 256.
// Results cannot be held off: each is on rsp_data for the one cycle of rsp_strobe.
module linear_probe_hash_set_core
   import lphs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   fsm_type             state_ff, state_in;
   logic [CSR_W-1:0]    csr_size_ff;
   func_type            func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    size_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic [CNT_W-1:0]    probes_ff;
   logic                have_free_ff;
   logic [IDX_W-1:0]    free_at_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   status_type          status_ff;

   logic             accept;
   logic [CNT_W-1:0] size_eff;
   logic             div_done;
   logic [IDX_W-1:0] div_rem;
   logic             load_fail;
   logic [LOAD_W-1:0] load_lhs, load_rhs;

   tbl_req_type tbl_req;
   tbl_rd_type  tbl_rd;

   logic             chk_finish;
   status_type       chk_status;
   logic             chk_wr;
   logic [IDX_W-1:0] chk_wr_addr;
   slot_state_type   chk_wr_slot;
   logic             chk_match;
   logic             chk_last;
   logic [IDX_W-1:0] slot_wrap;

   assign accept = start && !busy;

   always_comb begin
      if (csr_size_ff == '0) begin
         size_eff = CNT_W'(1);
      end else if (32'(csr_size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         size_eff = CNT_W'(csr_size_ff);
      end
   end

   assign load_lhs  = (LOAD_W'(count_ff) + LOAD_W'(1)) * LOAD_W'(10);
   assign load_rhs  = LOAD_W'(size_ff) * LOAD_W'(7);
   assign load_fail = (func_ff == FUNC_INSERT) && (load_lhs > load_rhs);

   lphs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (accept),
      .dividend  (req_data.key),
      .divisor   (size_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   lphs_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rd  (tbl_rd)
   );

   // probe decision on the slot just read
   assign chk_match = (tbl_rd.slot == SLOT_USED) && (tbl_rd.key == key_ff);
   assign chk_last  = (probes_ff + 1'b1) == size_ff;
   assign slot_wrap = ((CNT_W'(slot_ff) + 1'b1) == size_ff) ? '0 : slot_ff + 1'b1;

   always_comb begin
      chk_finish  = 1'b0;
      chk_status  = ST_DONE;
      chk_wr      = 1'b0;
      chk_wr_addr = slot_ff;
      chk_wr_slot = SLOT_USED;
      count_in    = count_ff;
      if (func_ff == FUNC_INSERT) begin
         if (chk_match) begin
            chk_finish = 1'b1;
            chk_status = ST_DUP;
         end else if (tbl_rd.slot == SLOT_EMPTY || chk_last) begin
            chk_finish = 1'b1;
            if (have_free_ff) begin
               chk_wr      = 1'b1;
               chk_wr_addr = free_at_ff;
               count_in    = count_ff + 1'b1;
            end else if (tbl_rd.slot != SLOT_USED) begin
               chk_wr   = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               chk_status = ST_FULL;
            end
         end
      end else begin
         if (tbl_rd.slot == SLOT_EMPTY) begin
            chk_finish = 1'b1;
            chk_status = ST_MISSING;
         end else if (chk_match) begin
            chk_finish  = 1'b1;
            chk_wr      = 1'b1;
            chk_wr_slot = SLOT_TOMB;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end else if (chk_last) begin
            chk_finish = 1'b1;
            chk_status = ST_MISSING;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_DIV;
            end
         end
         FSM_DIV: begin
            if (div_done) begin
               state_in = load_fail ? FSM_RESP : FSM_ISSUE;
            end
         end
         FSM_ISSUE: state_in = FSM_CHECK;
         FSM_CHECK: state_in = chk_finish ? FSM_RESP : FSM_ISSUE;
         FSM_RESP:  state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      busy                 = (state_ff != FSM_IDLE);
      rsp_strobe           = (state_ff == FSM_RESP);
      rsp_data.status      = status_ff;
      rsp_data.entry_total = count_ff;
      tbl_req.rd_en        = (state_ff == FSM_ISSUE);
      tbl_req.rd_addr      = slot_ff;
      tbl_req.wr_en        = (state_ff == FSM_CHECK) && chk_wr;
      tbl_req.wr_addr      = chk_wr_addr;
      tbl_req.wr_slot      = chk_wr_slot;
      tbl_req.wr_key       = key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_IDLE;
         csr_size_ff <= CSR_RESET;
         count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            csr_size_ff <= csr_wr_data;
         end
         if (state_ff == FSM_CHECK && chk_finish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff      <= func_type'(req_data.func);
         key_ff       <= req_data.key;
         size_ff      <= size_eff;
         probes_ff    <= '0;
         have_free_ff <= 1'b0;
      end
      if (state_ff == FSM_DIV && div_done) begin
         slot_ff   <= div_rem;
         status_ff <= ST_LOAD;
      end
      if (state_ff == FSM_CHECK) begin
         if (chk_finish) begin
            status_ff <= chk_status;
         end else begin
            // remember the first free slot, advance the probe
            if (!have_free_ff && tbl_rd.slot == SLOT_TOMB) begin
               have_free_ff <= 1'b1;
               free_at_ff   <= slot_ff;
            end
            probes_ff <= probes_ff + 1'b1;
            slot_ff   <= slot_wrap;
         end
      end
   end

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transfer did not start an operation");

   a_resp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("result not followed by idle");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> 32'(rsp_data.entry_total) <= 32'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_load_keeps_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_LOAD |-> $stable(count_ff))
      else $error("count changed on load refusal");

endmodule

// ----- rtl/core/lphs_mod.sv -----
module lphs_mod
   import lphs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [CNT_W-1:0]    divisor,
   output logic                done,
   output logic [IDX_W-1:0]    remainder
);

   localparam int REM_W = CNT_W + 1;

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIV_BITS-1:0]  shift_ff, shift_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [REM_W-1:0]     rem_next;

   // four restoring steps a cycle, top dividend bits first
   always_comb begin
      logic [REM_W-1:0] r;
      r = rem_ff;
      for (int b = 0; b < DIV_RADIX_BITS; b++) begin
         r = {r[REM_W-2:0], shift_ff[DIV_BITS-1-b]};
         if (r >= REM_W'(div_ff)) begin
            r = r - REM_W'(div_ff);
         end
      end
      rem_next = r;
   end

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      if (go) begin
         running_in = 1'b1;
         step_in    = '0;
         shift_in   = DIV_BITS'(dividend);
         rem_in     = '0;
         div_in     = divisor;
      end else if (running_ff) begin
         shift_in = shift_ff << DIV_RADIX_BITS;
         rem_in   = rem_next;
         step_in  = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

// ----- rtl/core/lphs_table.sv -----
module lphs_table
   import lphs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl_req,
   output tbl_rd_type  tbl_rd
);

   logic [KEY_BITS+1:0]    mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [KEY_BITS+1:0]    rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= {tbl_req.wr_slot, tbl_req.wr_key};
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   // an entry never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl_req.wr_en) begin
            valid_ff[tbl_req.wr_addr] <= 1'b1;
         end
         if (tbl_req.rd_en) begin
            rd_valid_ff <= valid_ff[tbl_req.rd_addr];
         end
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         tbl_rd.slot = slot_state_type'(rd_data_ff[KEY_BITS+1:KEY_BITS]);
      end else begin
         tbl_rd.slot = SLOT_EMPTY;
      end
      tbl_rd.key = rd_data_ff[KEY_BITS-1:0];
   end

endmodule

// ----- tb/tb_linear_probe_hash_set_core.sv -----
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_core;
   import lphs_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;
   localparam int NUM_PHASES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   linear_probe_hash_set_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // shadow of the set
   slot_state_type slot_mark [TABLE_DEPTH];
   logic [KEY_BITS-1:0] slot_key_copy [TABLE_DEPTH];
   int unsigned set_count;
   logic [CSR_W-1:0] size_reg;

   req_type pending_ops [$];
   rsp_type expected_outcomes [$];
   logic [KEY_BITS-1:0] live_keys [$];

   int send_idle_pct = 33;
   int error_count = 0;
   int stall_cycles = 0;

   int unsigned phase_size [NUM_PHASES] =
      '{1, 256, 10, 511, 37, 10, 37, 0, 7, 257, 100, 3, 16, 5, 64, 2};
   int phase_items [NUM_PHASES] =
      '{60, 120, 130, 120, 120, 120, 100, 60, 120, 120, 120, 130, 120, 130, 120, 100};
   bit phase_carry [NUM_PHASES] =
      '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   function automatic int unsigned eff_slots(logic [CSR_W-1:0] size);
      if (size == 0) return 1;
      if (size > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(size);
   endfunction

   function automatic rsp_type apply_set_op(req_type op);
      int unsigned s, home, idx, free_idx, i;
      bit have_free, stop;
      status_type st;
      rsp_type outcome;
      s = eff_slots(size_reg);
      home = op.key % s;
      stop = 1'b0;
      have_free = 1'b0;
      free_idx = 0;
      if (op.func == FUNC_INSERT) begin
         st = ST_DONE;
         if (10 * (set_count + 1) > 7 * s) begin
            st = ST_LOAD;
         end else begin
            // keep probing past tombstones so a later duplicate is still seen
            for (i = 0; i < s && !stop; i++) begin
               idx = home + i;
               if (idx >= s) idx -= s;
               if (slot_mark[idx] == SLOT_USED) begin
                  if (slot_key_copy[idx] == op.key) begin
                     st = ST_DUP;
                     stop = 1'b1;
                  end
               end else begin
                  if (!have_free) begin
                     have_free = 1'b1;
                     free_idx = idx;
                  end
                  if (slot_mark[idx] == SLOT_EMPTY) stop = 1'b1;
               end
            end
            if (st != ST_DUP) begin
               if (!have_free) begin
                  st = ST_FULL;
               end else begin
                  slot_mark[free_idx] = SLOT_USED;
                  slot_key_copy[free_idx] = op.key;
                  set_count++;
               end
            end
         end
      end else begin
         st = ST_MISSING;
         for (i = 0; i < s && !stop; i++) begin
            idx = home + i;
            if (idx >= s) idx -= s;
            if (slot_mark[idx] == SLOT_EMPTY) begin
               stop = 1'b1;
            end else if (slot_mark[idx] == SLOT_USED && slot_key_copy[idx] == op.key) begin
               slot_mark[idx] = SLOT_TOMB;
               if (set_count > 0) set_count--;
               st = ST_DONE;
               stop = 1'b1;
            end
         end
      end
      outcome.status = st;
      outcome.entry_total = set_count[CNT_W-1:0];
      return outcome;
   endfunction

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   // driver: hold start until the transfer, then present the next op
   always @(posedge clock) begin : drive_ops
      logic next_start;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_outcomes.push_back(apply_set_op(req_data));
            void'(pending_ops.pop_front());
            next_start = 1'b0;
         end
         if (!next_start && pending_ops.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_start = 1'b1;
            req_data <= pending_ops[0];
         end
      end
      start <= next_start;
   end

   always @(posedge clock) begin : check_outcomes
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            note_error($sformatf("unexpected result: status %0d entry_total %0d",
                                 rsp_data.status, rsp_data.entry_total));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.entry_total !== want.entry_total) begin
               note_error($sformatf("mismatch: status exp %0d got %0d, entry_total exp %0d got %0d",
                                    want.status, rsp_data.status,
                                    want.entry_total, rsp_data.entry_total));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_op(func_type f, logic [KEY_BITS-1:0] k);
      req_type item;
      item.func = f;
      item.key = k;
      pending_ops.push_back(item);
   endtask

   task automatic wait_until_drained();
      while (pending_ops.size() != 0 || expected_outcomes.size() != 0 || start || busy)
         @(posedge clock);
   endtask

   task automatic set_table_size(logic [CSR_W-1:0] v);
      wait_until_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = v;
   endtask

   // mix of full-range keys, keys clustered on a few home slots, and keys near the top
   function automatic logic [KEY_BITS-1:0] fresh_key(int unsigned se);
      int unsigned sel, home, lap_max;
      logic [31:0] k;
      sel = $urandom_range(5);
      if (sel < 2) begin
         k = $urandom();
      end else if (sel == 5) begin
         k = 32'h7FFF_FFFF - $urandom_range(3);
      end else begin
         home = $urandom_range(1) ? $urandom_range(se > 4 ? 3 : se - 1) : se - 1;
         lap_max = (32'h7FFF_FFFF - home) / se;
         k = se * $urandom_range(lap_max) + home;
      end
      return k[KEY_BITS-1:0];
   endfunction

   task automatic run_phase(int unsigned size, int n, bit carry);
      int unsigned se, r;
      int pick;
      logic [KEY_BITS-1:0] k;
      set_table_size(CSR_W'(size));
      se = eff_slots(CSR_W'(size));
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 45 || (r < 85 && live_keys.size() == 0)) begin
            k = fresh_key(se);
            push_op(FUNC_INSERT, k);
            live_keys.push_back(k);
         end else if (r < 55) begin
            push_op(FUNC_INSERT, live_keys[$urandom_range(live_keys.size() - 1)]);
         end else if (r < 85) begin
            pick = $urandom_range(live_keys.size() - 1);
            push_op(FUNC_DELETE, live_keys[pick]);
            live_keys.delete(pick);
         end else begin
            push_op(FUNC_DELETE, fresh_key(se));
         end
      end
      // empty the set again unless the keys are to be stranded by a size change
      if (!carry) begin
         while (live_keys.size() != 0) begin
            pick = $urandom_range(live_keys.size() - 1);
            push_op(FUNC_DELETE, live_keys[pick]);
            live_keys.delete(pick);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_mark[i] = SLOT_EMPTY;
         slot_key_copy[i] = '0;
      end
      set_count = 0;
      size_reg = CSR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full size after reset: collisions, wrap at the top slot, tombstone reuse
      push_op(FUNC_INSERT, 31'd0);
      push_op(FUNC_INSERT, 31'd0);
      push_op(FUNC_INSERT, 31'h7FFF_FFFF);
      push_op(FUNC_INSERT, 31'd256);
      push_op(FUNC_INSERT, 31'd511);
      push_op(FUNC_DELETE, 31'd256);
      push_op(FUNC_DELETE, 31'd511);
      push_op(FUNC_DELETE, 31'd511);
      push_op(FUNC_INSERT, 31'd512);
      push_op(FUNC_INSERT, 31'd512);
      push_op(FUNC_DELETE, 31'd0);
      push_op(FUNC_INSERT, 31'd768);
      push_op(FUNC_DELETE, 31'd12345);
      // zero clamps to one slot: load limit on any insert
      set_table_size(9'd0);
      push_op(FUNC_INSERT, 31'd5);
      push_op(FUNC_DELETE, 31'd5);
      push_op(FUNC_DELETE, 31'd768);
      // entries stranded beyond the size still count towards the load
      set_table_size(9'd3);
      push_op(FUNC_INSERT, 31'd1);
      set_table_size(9'd256);
      push_op(FUNC_DELETE, 31'd512);
      push_op(FUNC_DELETE, 31'h7FFF_FFFF);
      // two slots, both tombstones: probes walk the whole table
      set_table_size(9'd2);
      push_op(FUNC_INSERT, 31'd3);
      push_op(FUNC_INSERT, 31'd5);
      push_op(FUNC_DELETE, 31'd9);
      push_op(FUNC_DELETE, 31'd3);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p >= 11) send_idle_pct = 0;
         else if (p >= 5) send_idle_pct = 88;
         else send_idle_pct = 33;
         run_phase(phase_size[p], phase_items[p], phase_carry[p]);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/lphs_pkg.sv
rtl/core/lphs_mod.sv
rtl/core/lphs_table.sv
rtl/core/linear_probe_hash_set_core.sv
tb/tb_linear_probe_hash_set_core.sv
